// ----- sv/hbf_pkg.sv -----
// ----------------------------------------------------------------------------
// hbf_pkg
// shared widths, pipeline stage numbers and payload types of the harmonic
// bond force pipeline
// ----------------------------------------------------------------------------
package hbf_pkg;

  localparam int unsigned CRD_W = 32;   // Q16.16 coordinate
  localparam int unsigned LEN_W = 31;   // Q15.16 length, stiffness
  localparam int unsigned FRC_W = 48;   // Q32.16 force
  localparam int unsigned ENG_W = 63;   // Q47.16 energy
  localparam int unsigned IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_BOX_X = 2'd0;
  localparam logic [IDX_W-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BOX_Z = 2'd2;

  localparam logic [LEN_W-1:0] BOX_RESET = 31'd65536;
  localparam logic [ENG_W-1:0] ENG_MAX   = {ENG_W{1'b1}};

  // stage numbers, counted from the input register, and step counts
  localparam int unsigned REM_STEPS  = 32;
  localparam int unsigned ST_FOLD    = 33;
  localparam int unsigned ST_SQ      = 34;
  localparam int unsigned ST_SUM     = 35;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned ST_S       = 67;
  localparam int unsigned ST_K       = 68;
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned ST_M2      = 103;
  localparam int unsigned ST_TAIL    = 104;

  typedef struct packed {
    logic             last;
    logic [LEN_W-1:0] k;
    logic [LEN_W-1:0] rest;
  } early_t;

  typedef struct packed {
    logic [2:0][LEN_W-1:0] dabs;
    logic [2:0]            dneg;
  } sep_t;

  typedef struct packed {
    logic             last;
    logic             knz;
    logic             sneg;
    logic             snz;
    logic [2:0]       dneg;
    logic [2:0]       dnz;
    logic [LEN_W-1:0] k;
    logic [61:0]      ks;
    logic [61:0]      sm2;
  } late_t;

  typedef struct packed {
    logic [2:0][FRC_W-1:0] frc;
    logic [ENG_W-1:0]      energy;
    logic                  done;
  } res_t;

endpackage

// ----- sv/hbf_fold.sv -----
// ----------------------------------------------------------------------------
// hbf_fold
// one axis: separation, bit-serial remainder by the box length over 32
// stages, minimum-image fold to sign and magnitude, then its square
// ----------------------------------------------------------------------------
module hbf_fold (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hbf_pkg::LEN_W-1:0]  box_len,
  input  logic signed [hbf_pkg::CRD_W-1:0] first,
  input  logic signed [hbf_pkg::CRD_W-1:0] second,
  output logic [hbf_pkg::LEN_W-1:0]  dabs,
  output logic                       dneg,
  output logic [61:0]                sq
);
  import hbf_pkg::*;

  logic [LEN_W-1:0]  leff;
  logic signed [32:0] dr;
  logic signed [32:0] dr_neg;
  logic [31:0]       drabs;

  logic [LEN_W-1:0] rem_r [0:REM_STEPS];
  logic [31:0]      num_r [0:REM_STEPS];
  logic             neg_r [0:REM_STEPS];

  logic [LEN_W-1:0] m;
  logic             over;
  logic [LEN_W-1:0] dabs_nxt;
  logic [LEN_W-1:0] dabs_r;
  logic             dneg_r;
  logic [61:0]      sq_r;

  // a zero length behaves as the smallest length
  assign leff   = (box_len == '0) ? LEN_W'(1) : box_len;
  assign dr     = 33'(first) - 33'(second);
  assign dr_neg = -dr;
  assign drabs  = dr[32] ? dr_neg[31:0] : dr[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      num_r[0] <= drabs;
      neg_r[0] <= dr[32];
    end
  end

  for (genvar j = 1; j <= REM_STEPS; j++) begin : g_rem
    logic [31:0]      t;
    logic             ge;
    logic [LEN_W-1:0] rem_nxt;
    always_comb begin
      t       = {rem_r[j-1], num_r[j-1][31]};
      ge      = t >= {1'b0, leff};
      rem_nxt = ge ? LEN_W'(t - {1'b0, leff}) : t[LEN_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        num_r[j] <= {num_r[j-1][30:0], 1'b0};
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  // floor modulo, then half a box or less stays positive
  always_comb begin
    m        = (neg_r[REM_STEPS] && rem_r[REM_STEPS] != '0) ?
               leff - rem_r[REM_STEPS] : rem_r[REM_STEPS];
    over     = {m, 1'b0} > {1'b0, leff};
    dabs_nxt = over ? leff - m : m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dabs_r <= dabs_nxt;
      dneg_r <= over;
      sq_r   <= dabs_r * dabs_r;
    end
  end

  assign dabs = dabs_r;
  assign dneg = dneg_r;
  assign sq   = sq_r;

endmodule

// ----- sv/hbf_div.sv -----
// ----------------------------------------------------------------------------
// hbf_div
// direction cosine magnitude: floor(dm * 2^32 / r) by restoring division,
// one quotient bit per stage over 33 stages (dm never exceeds r)
// ----------------------------------------------------------------------------
module hbf_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hbf_pkg::LEN_W-1:0] r,
  input  logic [hbf_pkg::LEN_W-1:0] dm,
  output logic [32:0]               u
);
  import hbf_pkg::*;

  logic [LEN_W-1:0] drem_r [0:DIV_STEPS-1];
  logic [LEN_W-1:0] dv_r   [0:DIV_STEPS-1];
  logic [32:0]      q_r    [0:DIV_STEPS-1];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [31:0]      t;
    logic [LEN_W-1:0] dv;
    logic [32:0]      q_prev;
    logic             ge;
    logic [LEN_W-1:0] rem_nxt;
    if (j == 0) begin : g_head
      assign t      = {1'b0, dm};
      assign dv     = r;
      assign q_prev = '0;
    end else begin : g_body
      assign t      = {drem_r[j-1], 1'b0};
      assign dv     = dv_r[j-1];
      assign q_prev = q_r[j-1];
    end
    always_comb begin
      ge      = t >= {1'b0, dv};
      rem_nxt = ge ? LEN_W'(t - {1'b0, dv}) : t[LEN_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= rem_nxt;
        dv_r[j]   <= dv;
        q_r[j]    <= {q_prev[31:0], ge};
      end
    end
  end

  assign u = q_r[DIV_STEPS-1];

endmodule

// ----- sv/harmonic_bond_force.sv -----
// ----------------------------------------------------------------------------
// harmonic_bond_force
// harmonic bond force and running energy with minimum-image separation,
// one bond per word through a 105-stage pipeline
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    two site positions, rest length, stiffness, last
//  out      out_valid/out_ready  force on second site, running energy, sweep_done
//  cfg      cfg_we               cfg_index, cfg_wdata (box lengths)
//
//  one word per cycle while in_ready is high, that is while the skid stage is empty
//  the depth is set by the 32-step remainder, 31-step root and 33-step divider
//  the whole pipe moves together while the skid stage is empty; bubbles flow
//  rst_n (synchronous) clears valid bits and the energy sum and sets unit box lengths
// ----------------------------------------------------------------------------
module harmonic_bond_force #(
  parameter int unsigned DIMS = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [hbf_pkg::CRD_W-1:0] in_first_x,
  input  logic signed [hbf_pkg::CRD_W-1:0] in_first_y,
  input  logic signed [hbf_pkg::CRD_W-1:0] in_first_z,
  input  logic signed [hbf_pkg::CRD_W-1:0] in_second_x,
  input  logic signed [hbf_pkg::CRD_W-1:0] in_second_y,
  input  logic signed [hbf_pkg::CRD_W-1:0] in_second_z,
  input  logic [hbf_pkg::LEN_W-1:0]        in_rest_length,
  input  logic [hbf_pkg::LEN_W-1:0]        in_stiffness,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [hbf_pkg::FRC_W-1:0] out_force_x,
  output logic signed [hbf_pkg::FRC_W-1:0] out_force_y,
  output logic signed [hbf_pkg::FRC_W-1:0] out_force_z,
  output logic [hbf_pkg::ENG_W-1:0]        out_energy_sum,
  output logic                             out_sweep_done,
  input  logic                             cfg_we,
  input  logic [hbf_pkg::IDX_W-1:0]        cfg_index,
  input  logic [hbf_pkg::LEN_W-1:0]        cfg_wdata
);
  import hbf_pkg::*;

  logic                    en;
  logic [2:0][LEN_W-1:0]   box_r;
  logic [ST_TAIL:0]        v_r;

  logic [2:0][CRD_W-1:0]   first_v;
  logic [2:0][CRD_W-1:0]   second_v;
  logic [2:0][LEN_W-1:0]   fold_dabs;
  logic [2:0]              fold_dneg;
  logic [2:0][61:0]        fold_sq;
  logic [2:0][32:0]        u_v;

  early_t                  early_r [0:ST_S];
  sep_t                    sep_r   [ST_SQ:ST_K];
  late_t                   late_r  [ST_K:ST_M2];

  logic [61:0]             sqn_r  [0:SQRT_STEPS];
  logic [32:0]             srem_r [0:SQRT_STEPS];
  logic [LEN_W-1:0]        root_r [0:SQRT_STEPS];

  logic signed [31:0]      sdiff;
  logic [LEN_W-1:0]        smag_nxt;
  logic [LEN_W-1:0]        r67_r;
  logic [LEN_W-1:0]        smag67_r;
  logic                    sneg67_r;
  logic [LEN_W-1:0]        r68_r;

  logic [2:0][63:0]        pf_lo_r;
  logic [2:0][63:0]        pf_hi_r;
  logic [61:0]             pe_lo_r;
  logic [61:0]             pe_hi_r;
  logic [2:0][94:0]        pf_full;
  logic [92:0]             e_full;
  logic [2:0][46:0]        mag_r;
  logic [59:0]             e_r;

  logic [2:0][FRC_W-1:0]   frc_nxt;
  logic [63:0]             tot;
  logic [ENG_W-1:0]        tot_sat;
  logic [ENG_W-1:0]        acc_r;
  res_t                    tail_r;

  res_t                    obuf_r;
  logic                    obuf_v_r;
  res_t                    skid_r;
  logic                    skid_v_r;

  // the pipe moves whenever the skid stage has room
  assign en       = !skid_v_r;
  assign in_ready = en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= {BOX_RESET, BOX_RESET, BOX_RESET};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_X: box_r[0] <= cfg_wdata;
        CFG_BOX_Y: box_r[1] <= cfg_wdata;
        CFG_BOX_Z: box_r[2] <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST_TAIL-1:0], in_valid};
    end
  end

  assign first_v  = {in_first_z, in_first_y, in_first_x};
  assign second_v = {in_second_z, in_second_y, in_second_x};

  // per-axis lanes: fold and divider
  for (genvar a = 0; a < 3; a++) begin : g_lane
    if (a < DIMS) begin : g_on
      hbf_fold u_fold (
        .clk     (clk),
        .en      (en),
        .box_len (box_r[a]),
        .first   ($signed(first_v[a])),
        .second  ($signed(second_v[a])),
        .dabs    (fold_dabs[a]),
        .dneg    (fold_dneg[a]),
        .sq      (fold_sq[a])
      );
      hbf_div u_div (
        .clk (clk),
        .en  (en),
        .r   (r68_r),
        .dm  (sep_r[ST_K].dabs[a]),
        .u   (u_v[a])
      );
    end else begin : g_off
      assign fold_dabs[a] = '0;
      assign fold_dneg[a] = 1'b0;
      assign fold_sq[a]   = '0;
      assign u_v[a]       = '0;
    end
  end

  // side data delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      early_r[0] <= early_t'{last: in_last, k: in_stiffness, rest: in_rest_length};
      for (int j = 1; j <= ST_S; j++) early_r[j] <= early_r[j-1];
      sep_r[ST_SQ] <= sep_t'{dabs: fold_dabs, dneg: fold_dneg};
      for (int j = ST_SQ + 1; j <= ST_K; j++) sep_r[j] <= sep_r[j-1];
    end
  end

  // squared distance, then the integer root two bits a stage
  always_ff @(posedge clk) begin
    if (en) begin
      sqn_r[0]  <= fold_sq[0] + fold_sq[1] + fold_sq[2];
      srem_r[0] <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    logic [33:0] t;
    logic [33:0] trial;
    logic        ge;
    always_comb begin
      t     = {srem_r[k-1][31:0], sqn_r[k-1][61:60]};
      trial = {1'b0, root_r[k-1], 2'b01};
      ge    = t >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k] <= ge ? 33'(t - trial) : t[32:0];
        root_r[k] <= {root_r[k-1][LEN_W-2:0], ge};
        sqn_r[k]  <= {sqn_r[k-1][59:0], 2'b00};
      end
    end
  end

  // stretch
  always_comb begin
    sdiff    = {1'b0, root_r[SQRT_STEPS]} - {1'b0, early_r[ST_S-1].rest};
    smag_nxt = sdiff[31] ? LEN_W'(-sdiff) : sdiff[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r67_r    <= root_r[SQRT_STEPS];
      smag67_r <= smag_nxt;
      sneg67_r <= sdiff[31];
      r68_r    <= r67_r;
      late_r[ST_K] <= late_t'{
        last: early_r[ST_S].last,
        knz:  early_r[ST_S].k != '0,
        sneg: sneg67_r,
        snz:  smag67_r != '0,
        dneg: sep_r[ST_K-1].dneg,
        dnz:  {sep_r[ST_K-1].dabs[2] != '0, sep_r[ST_K-1].dabs[1] != '0,
               sep_r[ST_K-1].dabs[0] != '0},
        k:    early_r[ST_S].k,
        ks:   early_r[ST_S].k * smag67_r,
        sm2:  smag67_r * smag67_r
      };
      for (int j = ST_K + 1; j <= ST_M2; j++) late_r[j] <= late_r[j-1];
    end
  end

  // partial products of k*s*u and k*s^2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        pf_lo_r[a] <= late_r[ST_M2-2].ks[30:0] * u_v[a];
        pf_hi_r[a] <= late_r[ST_M2-2].ks[61:31] * u_v[a];
      end
      pe_lo_r <= late_r[ST_M2-2].sm2[30:0] * late_r[ST_M2-2].k;
      pe_hi_r <= late_r[ST_M2-2].sm2[61:31] * late_r[ST_M2-2].k;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pf_full[a] = {pf_hi_r[a], 31'd0} + {31'd0, pf_lo_r[a]};
    end
    e_full = {pe_hi_r, 31'd0} + {31'd0, pe_lo_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) mag_r[a] <= pf_full[a][94:48];
      e_r <= e_full[92:33];
    end
  end

  // sign, gating and the running sum
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (late_r[ST_M2].dnz[a] && late_r[ST_M2].snz && late_r[ST_M2].knz) begin
        frc_nxt[a] = (late_r[ST_M2].sneg != late_r[ST_M2].dneg[a]) ?
                     FRC_W'(0) - {1'b0, mag_r[a]} : {1'b0, mag_r[a]};
      end else begin
        frc_nxt[a] = '0;
      end
    end
    tot     = {1'b0, acc_r} + {4'd0, e_r};
    tot_sat = tot[63] ? ENG_MAX : tot[ENG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r <= res_t'{frc: frc_nxt, energy: tot_sat, done: late_r[ST_M2].last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en && v_r[ST_M2]) begin
      acc_r <= late_r[ST_M2].last ? '0 : tot_sat;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!obuf_v_r || out_ready) begin
      if (skid_v_r) begin
        obuf_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        obuf_v_r <= v_r[ST_TAIL];
      end
    end else if (en && v_r[ST_TAIL]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!obuf_v_r || out_ready) begin
      obuf_r <= skid_v_r ? skid_r : tail_r;
    end else if (en && v_r[ST_TAIL]) begin
      skid_r <= tail_r;
    end
  end

  assign out_valid      = obuf_v_r;
  assign out_force_x    = obuf_r.frc[0];
  assign out_force_y    = obuf_r.frc[1];
  assign out_force_z    = obuf_r.frc[2];
  assign out_energy_sum = obuf_r.energy;
  assign out_sweep_done = obuf_r.done;

`ifndef SYNTHESIS
  a_skid_needs_obuf: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> obuf_v_r)
    else $error("skid word held with empty output register");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(obuf_v_r && !out_ready))
    else $error("skid stage filled without an output stall");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[ST_M2] && late_r[ST_M2].last) |=> (acc_r == '0))
    else $error("energy sum not cleared after the last bond");

  a_zero_k_force: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[ST_M2] && !late_r[ST_M2].knz) |=> (tail_r.frc == '0))
    else $error("force from a bond with zero stiffness");
`endif

endmodule

// ----- verif/tb_harmonic_bond_force.sv -----
// ----------------------------------------------------------------------------
// tb_harmonic_bond_force
// self-checking bench for the harmonic bond force pipeline: bonds stream in
// bursts from a queue, an in-bench model predicts force and running energy
// per accepted word, and the monitor checks each result word in order
// ----------------------------------------------------------------------------
module tb_harmonic_bond_force;
  import hbf_pkg::*;

  typedef struct packed {
    logic signed [CRD_W-1:0] fx, fy, fz, sx, sy, sz;
    logic [LEN_W-1:0]        rest;
    logic [LEN_W-1:0]        k;
    logic                    last;
  } bond_t;

  typedef struct packed {
    logic [FRC_W-1:0] fx, fy, fz;
    logic [ENG_W-1:0] energy;
    logic             done;
  } bond_res_t;

  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [63:0] E_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] F_SAT = 64'd140737488355327;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bond_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FRC_W-1:0] out_force_x, out_force_y, out_force_z;
  logic [ENG_W-1:0] out_energy_sum;
  logic out_sweep_done;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  harmonic_bond_force dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_x(in_word.fx), .in_first_y(in_word.fy), .in_first_z(in_word.fz),
    .in_second_x(in_word.sx), .in_second_y(in_word.sy), .in_second_z(in_word.sz),
    .in_rest_length(in_word.rest), .in_stiffness(in_word.k), .in_last(in_word.last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_force_x(out_force_x), .out_force_y(out_force_y), .out_force_z(out_force_z),
    .out_energy_sum(out_energy_sum), .out_sweep_done(out_sweep_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bond_t     bond_queue[$];
  bond_res_t force_queue[$];
  logic [LEN_W-1:0] box_copy[3];
  logic [63:0] energy_run;
  int n_bonds = 0, n_results = 0, n_errors = 0, n_sweeps = 0, n_sat = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;
  int stall_mode = 0, stall_period = 4, stall_duty = 2, stall_cnt = 0;

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res, bit_v, rem;
    res = 0;
    rem = n;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint min_image(input longint dr, input logic [LEN_W-1:0] len);
    longint l, m;
    l = (len == 0) ? 64'sd1 : longint'({33'd0, len});
    m = dr % l;
    if (m < 0) m = m + l;
    if (2 * m > l) m = m - l;
    return m;
  endfunction

  function automatic logic [63:0] prod_shift(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  task automatic bond_predict(input bond_t b, output bond_res_t r);
    longint d[3];
    logic [63:0] sum, rlen, smag, e, tot, dm, u, mag;
    longint s, f;
    logic [FRC_W-1:0] fo[3];
    d[0] = min_image(longint'(b.fx) - longint'(b.sx), box_copy[0]);
    d[1] = min_image(longint'(b.fy) - longint'(b.sy), box_copy[1]);
    d[2] = min_image(longint'(b.fz) - longint'(b.sz), box_copy[2]);
    sum = 0;
    for (int a = 0; a < 3; a++) sum = sum + 64'(d[a] * d[a]);
    rlen = root_floor(sum);
    s = longint'(rlen) - longint'({33'd0, b.rest});
    smag = (s < 0) ? 64'(-s) : 64'(s);
    e = prod_shift(smag * smag, {33'd0, b.k}, 33);
    tot = energy_run + e;
    if (tot > E_SAT || tot < energy_run) begin
      tot = E_SAT;
      n_sat++;
    end
    for (int a = 0; a < 3; a++) begin
      f = 0;
      if (rlen != 0 && b.k != 0 && d[a] != 0 && smag != 0) begin
        dm = (d[a] < 0) ? 64'(-d[a]) : 64'(d[a]);
        u = (dm << 32) / rlen;
        mag = prod_shift({33'd0, b.k} * smag, u, 48);
        if (mag > F_SAT) mag = F_SAT;
        f = ((s < 0) != (d[a] < 0)) ? -longint'(mag) : longint'(mag);
      end
      fo[a] = f[FRC_W-1:0];
    end
    r.fx = fo[0];
    r.fy = fo[1];
    r.fz = fo[2];
    r.energy = tot[ENG_W-1:0];
    r.done = b.last;
    energy_run = b.last ? 64'd0 : tot;
  endtask

  // monitor: predicts on input acceptance, checks on output acceptance
  always @(posedge clk) begin
    bond_res_t want, got;
    if (!rst_n) begin
      box_copy[0] <= BOX_RESET;
      box_copy[1] <= BOX_RESET;
      box_copy[2] <= BOX_RESET;
      energy_run = 0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we && cfg_index != CFG_SPARE) box_copy[cfg_index] <= cfg_wdata;
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        bond_predict(in_word, want);
        force_queue.push_back(want);
        n_bonds++;
        if (in_word.last) n_sweeps++;
      end
      if (out_valid && out_ready) begin
        got = '{out_force_x, out_force_y, out_force_z, out_energy_sum, out_sweep_done};
        n_results++;
        if (force_queue.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result word %0d: %p", n_results, got);
        end else begin
          want = force_queue.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch word %0d: expected %p got %p", n_results, want, got);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && force_queue.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // driver: bursts of words with random gaps, and the out_ready stall pattern
  always @(negedge clk) begin
    logic nv;
    bond_t nw;
    int gap_left, burst_left;
    nv = in_valid;
    nw = in_word;
    if (rst_n && (!in_valid || in_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (bond_queue.size() > 0) begin
        nw = bond_queue.pop_front();
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= nv;
    in_word <= nw;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: begin
        out_ready <= (stall_cnt < stall_duty);
        stall_cnt <= (stall_cnt + 1 >= stall_period) ? 0 : stall_cnt + 1;
      end
    endcase
  end

  task automatic write_box(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (bond_queue.size() == 0 && !in_valid && force_queue.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic bond_t random_bond(input logic [LEN_W-1:0] span);
    bond_t b;
    int sh;
    b.fx = $urandom;
    b.fy = $urandom;
    b.fz = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      b.sx = $urandom;
      b.sy = $urandom;
      b.sz = $urandom;
    end else begin
      // second site a short hop from the first, of random scale
      sh = $urandom_range(0, 31);
      b.sx = b.fx + ($signed($urandom) >>> sh);
      b.sy = b.fy + ($signed($urandom) >>> sh);
      b.sz = b.fz + ($signed($urandom) >>> sh);
    end
    b.rest = ($urandom_range(0, 1) == 0) ? (span >> $urandom_range(1, 4)) :
             LEN_W'($urandom >> $urandom_range(1, 31));
    b.k = ($urandom_range(0, 9) == 0) ? '0 : LEN_W'($urandom >> $urandom_range(1, 31));
    b.last = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  task automatic push_random(input int count, input logic [LEN_W-1:0] span);
    for (int i = 0; i < count; i++) bond_queue.push_back(random_bond(span));
  endtask

  task automatic push_bond(input logic signed [CRD_W-1:0] dx, dy, dz,
                           input logic [LEN_W-1:0] rest, k, input logic last);
    bond_t b;
    b.fx = dx;
    b.fy = dy;
    b.fz = dz;
    b.sx = '0;
    b.sy = '0;
    b.sz = '0;
    b.rest = rest;
    b.k = k;
    b.last = last;
    bond_queue.push_back(b);
  endtask

  localparam logic signed [CRD_W-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [CRD_W-1:0] CMIN = 32'sh8000_0000;
  localparam logic [LEN_W-1:0] LMAX = {LEN_W{1'b1}};

  initial begin
    bond_t b;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unit box from reset: ties, zero distance, zero stiffness, extremes
    push_bond(32'sd32768, 0, 0, 31'd1000, 31'd65536, 1'b0);
    push_bond(-32'sd32768, 32'sd32768, -32'sd32768, 31'd0, 31'd65536, 1'b0);
    push_bond(0, 0, 0, 31'd40000, 31'd65536, 1'b0);
    push_bond(0, 0, 0, LMAX, LMAX, 1'b0);
    push_bond(32'sd12345, -32'sd999, 32'sd7, 31'd100, 31'd0, 1'b1);
    push_bond(CMAX, CMIN, CMAX, 31'd0, LMAX, 1'b0);
    push_bond(CMIN, CMAX, -32'sd1, LMAX, 31'd1, 1'b0);
    push_bond(32'sd20000, 32'sd30000, -32'sd25000, 31'd5, 31'd3, 1'b1);
    b = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, LMAX, LMAX, 1'b0};
    bond_queue.push_back(b);
    b = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 31'd0, 31'd0, 1'b1};
    bond_queue.push_back(b);
    push_random(220, 31'd65536);
    wait_drained();

    // huge boxes, large energies with long unterminated sweeps
    stall_mode = 1;
    write_box(CFG_BOX_X, LMAX);
    write_box(CFG_BOX_Y, LMAX);
    write_box(CFG_BOX_Z, LMAX);
    write_box(CFG_SPARE, 31'd77);
    for (int i = 0; i < 10; i++) push_bond(32'sd1 <<< 29, -(32'sd1 <<< 29), 32'sd1 <<< 29,
                                          31'd0, LMAX, 1'b0);
    push_bond(CMAX, CMIN, 32'sd1, 31'd0, LMAX, 1'b1);
    push_random(220, LMAX);
    wait_drained();

    // zero and minimum box lengths collapse every separation
    stall_mode = 2;
    stall_period = $urandom_range(2, 9);
    stall_duty = $urandom_range(1, stall_period - 1);
    write_box(CFG_BOX_X, 31'd0);
    write_box(CFG_BOX_Y, 31'd1);
    write_box(CFG_BOX_Z, 31'd0);
    push_bond(0, 0, 0, 31'd65536, 31'd65536, 1'b1);
    push_random(220, 31'd1);
    wait_drained();

    for (int ph = 0; ph < 2; ph++) begin
      logic [LEN_W-1:0] bx;
      stall_mode = $urandom_range(0, 2);
      stall_period = $urandom_range(2, 12);
      stall_duty = $urandom_range(1, stall_period - 1);
      bx = LEN_W'((LEN_W'($urandom >> $urandom_range(1, 28)) | 31'd1) << 1);
      write_box(CFG_BOX_X, bx);
      write_box(CFG_BOX_Y, LEN_W'($urandom >> $urandom_range(1, 28)));
      write_box(CFG_BOX_Z, (ph == 0) ? 31'd2 : LMAX);
      // exact half-box tie along x
      push_bond(CRD_W'(bx >> 1) & {CRD_W{bx[0] == 1'b0}}, 32'sd3, -32'sd3,
                31'd1, 31'd65536, 1'b0);
      push_random(225, bx);
      wait_drained();
    end

    $display("%0d bonds over %0d sweeps across five box settings, %0d result words",
             n_bonds, n_sweeps, n_results);
    $display("energy saturated %0d times, %0d mismatches", n_sat, n_errors);
    if (n_errors == 0 && force_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hbf_pkg.sv
sv/hbf_fold.sv
sv/hbf_div.sv
sv/harmonic_bond_force.sv
verif/tb_harmonic_bond_force.sv
